// ===== design/rvht_pkg.sv =====
// Shared types and constants for the register value holder table.
// Used by rvht_cell and register_value_holder_table; depends on nothing.
`timescale 1ns / 1ps

package rvht_pkg;

    // Default table sizing
    localparam int DEF_NUM_REGISTERS = 64;
    localparam int DEF_VALUE_ID_BITS = 16;

    // Fixed field widths on the stream ports
    localparam int TGT_BITS = 6;
    localparam int VID_BITS = 16;
    localparam int SRC_BITS = 6;

    // Operation codes; code 3 means nothing and is ignored
    typedef enum logic [1:0] {
        OP_BLOCK_START  = 2'd0,
        OP_OPAQUE_WRITE = 2'd1,
        OP_STORE        = 2'd2
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // Search token flags carried from cell to cell
    typedef struct packed {
        logic active;
        logic found;
    } t_tok;

    // Table update command broadcast to every cell
    typedef struct packed {
        logic clear;
        logic en;
        logic set_valid;
    } t_wr;

endpackage

// ===== design/rvht_cell.sv =====
// One entry of the holder table: valid bit, held value id and a search token stage.
// Depends on rvht_pkg (t_tok, t_wr).
`timescale 1ns / 1ps

module rvht_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_BITS   = 6,
    parameter int VAL_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // token from the previous cell
    input  rvht_pkg::t_tok      i_tok,
    input  logic [IDX_BITS-1:0] i_tok_idx,
    // token to the next cell
    output rvht_pkg::t_tok      o_tok,
    output logic [IDX_BITS-1:0] o_tok_idx,
    // value id being searched
    input  logic [VAL_BITS-1:0] i_query,
    // table update
    input  rvht_pkg::t_wr       i_wr,
    input  logic [IDX_BITS-1:0] i_wr_idx,
    input  logic [VAL_BITS-1:0] i_wr_value
);

    logic                r_valid;
    logic [VAL_BITS-1:0] r_value;
    rvht_pkg::t_tok      r_tok;
    rvht_pkg::t_tok      n_tok;
    logic [IDX_BITS-1:0] r_tok_idx;
    logic [IDX_BITS-1:0] n_tok_idx;
    logic                w_match;
    logic                w_sel;

    assign w_match = r_valid && (r_value == i_query);
    assign w_sel   = (i_wr_idx == IDX_BITS'(CELL_INDEX));

    // First matching cell claims the token
    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (i_tok.active && !i_tok.found && w_match) begin
            n_tok.found = 1'b1;
            n_tok_idx   = IDX_BITS'(CELL_INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_tok_idx <= n_tok_idx;
    end

    // Entry update: clear drops all, a write touches the addressed entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.clear) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && w_sel) begin
            r_valid <= i_wr.set_valid;
        end
        if (i_wr.en && w_sel && i_wr.set_valid) begin
            r_value <= i_wr_value;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

// ===== design/register_value_holder_table.sv =====
// Top level of the register value holder table: stream ports, controller, cell chain.
// Depends on rvht_pkg and rvht_cell.
`timescale 1ns / 1ps
//
//  Channel   Direction  Fields
//  s_axis    in         tdata: target_register, value_id; tuser: operation, whole_write
//  m_axis    out        tdata: source_register; tuser: rewrite
//
//  A store searches the table with a token that steps one cell per cycle through
//  the chain of NUM_REGISTERS cells; when it leaves the last cell the outcome is latched
//  and then registered as the result; the next word can be taken the cycle after that.
//  Clears, ignored codes and out-of-range stores skip the search and go straight to DONE.
//  One word is in flight at a time; a waiting result holds the update and s_axis
//  tready until m_axis takes it. Reset is synchronous and empties the table at once.

module register_value_holder_table #(
    parameter int NUM_REGISTERS = rvht_pkg::DEF_NUM_REGISTERS,
    parameter int VALUE_ID_BITS = rvht_pkg::DEF_VALUE_ID_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [5:0] target_register, [21:6] value_id, zero pad
    input  logic [2:0]  s_axis_tuser,   // [1:0] operation, [2] whole_write
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] source_register, zero pad
    output logic        m_axis_tuser    // [0] rewrite
);

    localparam int IW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam int VW = (VALUE_ID_BITS < rvht_pkg::VID_BITS) ?
                        VALUE_ID_BITS : rvht_pkg::VID_BITS;

    rvht_pkg::t_state r_state, n_state;
    logic [1:0]                      r_op;
    logic [rvht_pkg::TGT_BITS-1:0]   r_target;
    logic [VW-1:0]                   r_value;
    logic                            r_whole;
    logic                            r_is_store;
    logic                            r_start, n_start;
    logic                            r_found;
    logic [IW-1:0]                   r_hold_idx;
    logic                            r_out_valid;
    logic                            r_out_rewrite;
    logic [rvht_pkg::SRC_BITS-1:0]   r_out_source;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_done_fire;
    logic                            w_in_store;
    logic [1:0]                      w_in_op;
    logic [rvht_pkg::TGT_BITS-1:0]   w_in_target;
    logic [IW-1:0]                   w_tgt_idx;
    logic                            w_self;
    logic                            w_rewrite;

    rvht_pkg::t_tok                  w_tok [NUM_REGISTERS+1];
    logic [IW-1:0]                   w_tok_idx [NUM_REGISTERS+1];
    rvht_pkg::t_wr                   w_wr;

    // Input decode
    assign w_in_op     = s_axis_tuser[1:0];
    assign w_in_target = s_axis_tdata[5:0];
    assign w_in_store  = (w_in_op == rvht_pkg::OP_STORE) &&
                         (32'(w_in_target) < NUM_REGISTERS);

    assign s_axis_tready = (r_state == rvht_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_done_fire   = (r_state == rvht_pkg::ST_DONE) && w_out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            rvht_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_store ? rvht_pkg::ST_SEARCH : rvht_pkg::ST_DONE;
                    n_start = w_in_store;
                end
            end
            rvht_pkg::ST_SEARCH: begin
                if (w_tok[NUM_REGISTERS].active) begin
                    n_state = rvht_pkg::ST_DONE;
                end
            end
            rvht_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = rvht_pkg::ST_IDLE;
                end
            end
            default: n_state = rvht_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rvht_pkg::ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // Latched word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= w_in_op;
            r_target   <= w_in_target;
            r_value    <= s_axis_tdata[6 +: VW];
            r_whole    <= s_axis_tuser[2];
            r_is_store <= w_in_store;
            r_found    <= 1'b0;
        end else if ((r_state == rvht_pkg::ST_SEARCH) && w_tok[NUM_REGISTERS].active) begin
            r_found    <= w_tok[NUM_REGISTERS].found;
            r_hold_idx <= w_tok_idx[NUM_REGISTERS];
        end
    end

    // Store outcome
    assign w_tgt_idx = IW'(r_target);
    assign w_self    = (r_hold_idx == w_tgt_idx);
    assign w_rewrite = r_is_store && r_whole && r_found && !w_self;

    always_comb begin
        w_wr.clear     = w_done_fire && ((r_op == rvht_pkg::OP_BLOCK_START) ||
                                         (r_op == rvht_pkg::OP_OPAQUE_WRITE));
        w_wr.en        = w_done_fire && r_is_store;
        w_wr.set_valid = r_whole && (!r_found || w_self);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done_fire) begin
            r_out_rewrite <= w_rewrite;
            r_out_source  <= w_rewrite ? rvht_pkg::SRC_BITS'(r_hold_idx) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_source};
    assign m_axis_tuser  = r_out_rewrite;

    // Cell chain; the token enters cell 0 the cycle after a store is taken
    assign w_tok[0]     = '{active: r_start, found: 1'b0};
    assign w_tok_idx[0] = '0;

    for (genvar g = 0; g < NUM_REGISTERS; g++) begin : g_cell
        rvht_cell #(
            .CELL_INDEX (g),
            .IDX_BITS   (IW),
            .VAL_BITS   (VW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_tok_idx  (w_tok_idx[g]),
            .o_tok      (w_tok[g+1]),
            .o_tok_idx  (w_tok_idx[g+1]),
            .i_query    (r_value),
            .i_wr       (w_wr),
            .i_wr_idx   (w_tgt_idx),
            .i_wr_value (r_value)
        );
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for register_value_holder_table: directed table, then random words.
// Depends on rvht_pkg and the design files; holds its own predictor of the holder table.
`timescale 1ns / 1ps

module tb;

    localparam int          NREG           = rvht_pkg::DEF_NUM_REGISTERS;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          WORDS_PER_PH   = 375;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = NREG + 16;
    localparam int          WATCHDOG_LIMIT = 2000;

    // One input word and one expected result
    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  tgt;
        logic [15:0] vid;
        logic        whole;
    } t_word;

    typedef struct packed {
        logic       rewrite;
        logic [5:0] src;
    } t_reuse;

    // Directed row: word, whether the result is typed in, and the typed result
    typedef struct packed {
        t_word  w;
        logic   known;
        t_reuse res;
    } t_row;

    localparam int NUM_ROWS = 23;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [5:0] target_register, [21:6] value_id, zero pad
    logic [2:0]  s_axis_tuser = '0;   // [1:0] operation, [2] whole_write
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [5:0] source_register, zero pad
    logic        m_axis_tuser;        // [0] rewrite

    // Predictor state: which register holds which value id
    logic        holds_q [NREG];
    logic [15:0] held_id [NREG];

    t_reuse      reuse_q [$];
    int          fail_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    logic [15:0] vid_pool [8];

    // Directed words: reuse, self-hold, partial writes, clears, ignored code, extremes
    t_row rows [NUM_ROWS] = '{
        '{'{rvht_pkg::OP_STORE,       6'd0,  16'h1234, 1'b1}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd63, 16'h1234, 1'b1}, 1'b1, '{1'b1, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd5,  16'h1234, 1'b0}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd0,  16'h1234, 1'b1}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd63, 16'hFFFF, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd1,  16'hFFFF, 1'b1}, 1'b1, '{1'b1, 6'd63}},
        '{'{OP_UNUSED,                6'd2,  16'h1234, 1'b1}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd2,  16'h1234, 1'b1}, 1'b1, '{1'b1, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd0,  16'h0000, 1'b0}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd3,  16'h1234, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd4,  16'h1234, 1'b1}, 1'b1, '{1'b1, 6'd3}},
        '{'{rvht_pkg::OP_BLOCK_START, 6'd9,  16'h1234, 1'b1}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd4,  16'h1234, 1'b1}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd62, 16'hFFFF, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_OPAQUE_WRITE,6'd62, 16'hFFFF, 1'b0}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd62, 16'hFFFF, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd0,  16'h0000, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd63, 16'h0000, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd0,  16'hAAAA, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd1,  16'h5555, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd2,  16'h0000, 1'b1}, 1'b0, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd33, 16'h5555, 1'b0}, 1'b1, '{1'b0, 6'd0}},
        '{'{rvht_pkg::OP_STORE,       6'd33, 16'h5555, 1'b1}, 1'b0, '{1'b0, 6'd0}}
    };

    register_value_holder_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Index of the register holding vid, or -1
    function automatic int find_holder(logic [15:0] vid);
        for (int i = 0; i < NREG; i++)
            if (holds_q[i] && held_id[i] == vid)
                return i;
        return -1;
    endfunction

    // Apply one word to the predicted table and return the expected result
    function automatic t_reuse track_holders(t_word w);
        t_reuse r;
        int     holder;
        r = '0;
        if (w.op == rvht_pkg::OP_BLOCK_START || w.op == rvht_pkg::OP_OPAQUE_WRITE) begin
            for (int i = 0; i < NREG; i++)
                holds_q[i] = 1'b0;
        end else if (w.op == rvht_pkg::OP_STORE) begin
            holder = find_holder(w.vid);
            if (holder >= 0 && holder != int'(w.tgt) && w.whole) begin
                r.rewrite = 1'b1;
                r.src     = holder[5:0];
            end
            holds_q[w.tgt] = 1'b0;
            if (w.whole && find_holder(w.vid) < 0) begin
                holds_q[w.tgt] = 1'b1;
                held_id[w.tgt] = w.vid;
            end
        end
        return r;
    endfunction

    // Offer one word, wait for the handshake, then record its expected result
    task automatic send_word(input t_word w, input logic known, input t_reuse typed);
        t_reuse pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, w.vid, w.tgt};
        s_axis_tuser  <= {w.whole, w.op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred = track_holders(w);
        if (known)
            pred = typed;
        reuse_q.insert(reuse_q.size(), pred);
    endtask

    // Random word: mostly whole stores drawn from a small value pool so holders collide
    function automatic t_word random_word();
        t_word w;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 4)
            w.op = rvht_pkg::OP_BLOCK_START;
        else if (pick < 7)
            w.op = rvht_pkg::OP_OPAQUE_WRITE;
        else if (pick < 10)
            w.op = OP_UNUSED;
        else
            w.op = rvht_pkg::OP_STORE;
        w.tgt   = ($urandom_range(1) == 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
        w.vid   = ($urandom_range(9) < 7) ? vid_pool[$urandom_range(7)] : 16'($urandom);
        w.whole = ($urandom_range(9) < 8);
        return w;
    endfunction

    // Sender clears out the valid and waits until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reuse_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_reuse exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reuse_q.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_cnt++;
            end else begin
                exp = reuse_q.pop_front();
                if (m_axis_tuser !== exp.rewrite) begin
                    $error("rewrite: expected %0d, got %0d", exp.rewrite, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata[5:0] !== exp.src) begin
                    $error("source_register: expected %0d, got %0d", exp.src,
                           m_axis_tdata[5:0]);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed rows, then four phases of random words with varied idling and stalls
    initial begin
        for (int i = 0; i < NREG; i++) begin
            holds_q[i] = 1'b0;
            held_id[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            for (int i = 0; i < 8; i++)
                vid_pool[i] = 16'($urandom);
            if (ph == 0) begin
                for (int r = 0; r < NUM_ROWS; r++)
                    send_word(rows[r].w, rows[r].known, rows[r].res);
                // receiver backs off while words keep coming
                hold_req = 1'b1;
            end
            for (int n = 0; n < WORDS_PER_PH; n++)
                send_word(random_word(), 1'b0, '0);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reuse_q.size() != 0) begin
            $error("%0d expected results never arrived", reuse_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== register_value_holder_table.f =====
design/rvht_pkg.sv
design/rvht_cell.sv
design/register_value_holder_table.sv
tb/tb.sv
